// File: rtl/hsv_color_blob_tracker_macros.svh
// Assertion macros shared by the tracker modules.
`ifndef HSV_COLOR_BLOB_TRACKER_MACROS_SVH
`define HSV_COLOR_BLOB_TRACKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define HCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/hcbt_pkg.sv
// Package with widths, register codes and word types of the tracker.
`timescale 1ns / 1ps
package hcbt_pkg;
    localparam int Width  = 160;
    localparam int Height = 120;
    localparam int ColW   = 8;
    localparam int RowW   = 7;
    localparam int CntW   = 15;
    localparam int SumW   = 22;
    localparam int QDepth = 4;

    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;
    localparam logic [2:0] REG_AREA     = 3'd6;

    typedef struct packed {
        logic [8:0]  hue_low;
        logic [8:0]  hue_high;
        logic [7:0]  sat_low;
        logic [7:0]  sat_high;
        logic [7:0]  val_low;
        logic [7:0]  val_high;
        logic [14:0] area_floor;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Classified pixel handed from front to back.
    typedef struct packed {
        logic            mark;
        logic            last;
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
    } t_cls;

    typedef struct packed {
        logic            is_target;
        logic            frame_done;
        logic            found;
        logic [7:0]      center_col;
        logic [6:0]      center_row;
        logic [7:0]      box_left;
        logic [6:0]      box_top;
        logic [7:0]      box_right;
        logic [6:0]      box_bottom;
        logic [14:0]     pixel_count;
    } t_result;

    typedef struct packed {
        logic [2:0]  index;
        logic [14:0] data;
    } t_cfg_word;
endpackage

// File: rtl/hcbt_stream_if.sv
// Valid/ready stream interfaces for pixels, results and configuration.
`timescale 1ns / 1ps
interface hcbt_pixel_if import hcbt_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hcbt_result_if import hcbt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hcbt_cfg_if import hcbt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/hsv_color_blob_tracker.sv
// Top level of the HSV color blob tracker.
//  channel  dir  word                          accepted
//  i_pix    in   red, green, blue              valid && ready
//  o_res    out  mask bit and frame statistics  valid && ready
//  i_cfg    in   register index, write data     valid && ready
// One pixel per cycle through a two-stage classifier, a four-entry queue and
// the statistics stage. The last pixel of a frame with enough marked pixels
// occupies the back end while the serial centroid divider runs and the result
// is loaded and delivered. Reset is synchronous and restores the
// register defaults. Either side may stall; the queue absorbs the difference.
`timescale 1ns / 1ps
module hsv_color_blob_tracker import hcbt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    hcbt_pixel_if.sink      i_pix,
    hcbt_result_if.source   o_res,
    hcbt_cfg_if.sink        i_cfg
);
    t_cfg r_cfg;
    logic f_valid;
    logic f_ready;
    t_cls f_cls;
    logic b_valid;
    logic b_ready;
    t_cls b_cls;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low    <= 9'd340;
            r_cfg.hue_high   <= 9'd20;
            r_cfg.sat_low    <= 8'd120;
            r_cfg.sat_high   <= 8'd255;
            r_cfg.val_low    <= 8'd80;
            r_cfg.val_high   <= 8'd255;
            r_cfg.area_floor <= 15'd10;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_HUE_LOW:  r_cfg.hue_low    <= i_cfg.data.data[8:0];
                REG_HUE_HIGH: r_cfg.hue_high   <= i_cfg.data.data[8:0];
                REG_SAT_LOW:  r_cfg.sat_low    <= i_cfg.data.data[7:0];
                REG_SAT_HIGH: r_cfg.sat_high   <= i_cfg.data.data[7:0];
                REG_VAL_LOW:  r_cfg.val_low    <= i_cfg.data.data[7:0];
                REG_VAL_HIGH: r_cfg.val_high   <= i_cfg.data.data[7:0];
                REG_AREA:     r_cfg.area_floor <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    hcbt_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(i_pix.valid), .o_ready(i_pix.ready), .i_pixel(i_pix.data),
        .o_valid(f_valid), .i_ready(f_ready), .o_cls(f_cls)
    );

    hcbt_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_cls(f_cls),
        .o_valid(b_valid), .i_ready(b_ready), .o_cls(b_cls)
    );

    hcbt_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(b_valid), .o_ready(b_ready), .i_cls(b_cls),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(o_res.data)
    );
endmodule

// File: rtl/hcbt_front.sv
// Front end: HSV window classification in two stages plus raster counters.
`timescale 1ns / 1ps
module hcbt_front import hcbt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pixel i_pixel,
    output logic   o_valid,
    input  logic   i_ready,
    output t_cls   o_cls
);
    // Stage 1 registers: value, spread, hue numerator, raster position.
    logic            r_v1;
    logic [7:0]      r_mx;
    logic [7:0]      r_d;
    logic [16:0]     r_num;
    logic            r_last1;
    logic [ColW-1:0] r_col1;
    logic [RowW-1:0] r_row1;
    logic            r_v2;
    t_cls            r_cls;
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;

    logic            adv2;
    logic            adv1;
    logic [7:0]      mx;
    logic [7:0]      mn;
    logic [7:0]      d;
    logic signed [17:0] num;
    logic [16:0]     n_num;
    logic            last;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_cls   = r_cls;

    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx) mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn) mn = i_pixel.blue;
        d = mx - mn;
        // The numerator stays below 360 times the spread, so it needs 17 bits unsigned.
        if (d == 8'd0) begin
            num = 18'sd0;
        end else if (mx == i_pixel.red) begin
            num = 18'(signed'({1'b0, i_pixel.green}) - signed'({1'b0, i_pixel.blue}))
                * 18'sd60;
            if (num < 0) num = num + 18'(signed'({1'b0, d})) * 18'sd360;
        end else if (mx == i_pixel.green) begin
            num = 18'(signed'({1'b0, i_pixel.blue}) - signed'({1'b0, i_pixel.red})) * 18'sd60
                + 18'(signed'({1'b0, d})) * 18'sd120;
        end else begin
            num = 18'(signed'({1'b0, i_pixel.red}) - signed'({1'b0, i_pixel.green})) * 18'sd60
                + 18'(signed'({1'b0, d})) * 18'sd240;
        end
        n_num = num[16:0];
        last  = (r_col == ColW'(Width - 1)) && (r_row == RowW'(Height - 1));
    end

    // Stage 2 products: cross-multiplied hue and saturation window checks, plus the value window check.
    logic [8:0]  dd;
    logic [16:0] lo_prod;
    logic [16:0] hi_prod;
    logic [15:0] s_d;
    logic [15:0] s_lo;
    logic [15:0] s_hi;
    logic        ge;
    logic        le;
    logic        hue_ok;
    logic        sat_ok;
    logic        val_ok;

    always_comb begin
        dd      = (r_d == 8'd0) ? 9'd1 : {1'b0, r_d};
        lo_prod = 17'(i_cfg.hue_low) * 17'(dd);
        hi_prod = 17'(i_cfg.hue_high) * 17'(dd);
        ge      = r_num >= lo_prod;
        le      = r_num <= hi_prod;
        hue_ok  = (i_cfg.hue_low > i_cfg.hue_high) ? (ge || le) : (ge && le);
        s_d     = 16'(r_d) * 16'd255;
        s_lo    = 16'(i_cfg.sat_low) * 16'(r_mx);
        s_hi    = 16'(i_cfg.sat_high) * 16'(r_mx);
        if (r_mx == 8'd0) sat_ok = (i_cfg.sat_low == 8'd0);
        else sat_ok = (s_d >= s_lo) && (s_d <= s_hi);
        val_ok  = (r_mx >= i_cfg.val_low) && (r_mx <= i_cfg.val_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (i_valid && adv1) begin
                if (r_col == ColW'(Width - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == RowW'(Height - 1)) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_mx    <= mx;
            r_d     <= d;
            r_num   <= n_num;
            r_last1 <= last;
            r_col1  <= r_col;
            r_row1  <= r_row;
        end
        if (adv2) begin
            r_cls.mark <= hue_ok && sat_ok && val_ok;
            r_cls.last <= r_last1;
            r_cls.col  <= r_col1;
            r_cls.row  <= r_row1;
        end
    end
endmodule

// File: rtl/hcbt_queue.sv
// Short FIFO of classified pixels between front and back.
`timescale 1ns / 1ps
`include "hsv_color_blob_tracker_macros.svh"
module hcbt_queue import hcbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_cls,
    output logic o_valid,
    input  logic i_ready,
    output t_cls o_cls
);
    localparam int AW = $clog2(QDepth);
    t_cls          r_mem [QDepth];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = r_cnt != (AW+1)'(QDepth);
    assign o_valid = r_cnt != '0;
    assign o_cls   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cls;
    end

    `HCB_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == (AW+1)'(QDepth), !push)
    `HCB_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 1'b1)
    `HCB_ASSERT_NEXT(a_cnt_dn, i_clk, i_rst_n, pop && !push, r_cnt == $past(r_cnt) - 1'b1)
endmodule

// File: rtl/hcbt_back.sv
// Back end: frame statistics, serial centroid division and result register.
`timescale 1ns / 1ps
`include "hsv_color_blob_tracker_macros.svh"
module hcbt_back import hcbt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cls    i_cls,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;
    localparam int CW = $clog2(SumW + 1);

    logic [1:0]      r_st;
    logic            r_ov;
    t_result         r_res;
    logic [SumW-1:0] r_csum;
    logic [SumW-1:0] r_rsum;
    logic [CntW-1:0] r_cnt;
    logic [ColW-1:0] r_lc;
    logic [ColW-1:0] r_mc;
    logic [RowW-1:0] r_lr;
    logic [RowW-1:0] r_mr;
    // Restoring divider state for both quotients at once.
    logic [SumW-1:0] r_qc;
    logic [SumW-1:0] r_qr;
    logic [CntW:0]   r_remc;
    logic [CntW:0]   r_remr;
    logic [CntW-1:0] r_div;
    logic [CW-1:0]   r_step;

    logic            take;
    logic            out_free;
    logic [SumW-1:0] n_csum;
    logic [SumW-1:0] n_rsum;
    logic [CntW-1:0] n_cnt;
    logic [ColW-1:0] n_lc;
    logic [ColW-1:0] n_mc;
    logic [RowW-1:0] n_lr;
    logic [RowW-1:0] n_mr;
    logic            found;
    logic [CntW:0]   tc;
    logic [CntW:0]   tr;
    logic            n_ov;
    t_result         n_res;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_st == ST_RUN) && out_free;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_ov;
    assign o_res    = r_res;

    always_comb begin
        n_csum = r_csum;
        n_rsum = r_rsum;
        n_cnt  = r_cnt;
        n_lc   = r_lc;
        n_mc   = r_mc;
        n_lr   = r_lr;
        n_mr   = r_mr;
        if (i_cls.mark) begin
            n_csum = r_csum + SumW'(i_cls.col);
            n_rsum = r_rsum + SumW'(i_cls.row);
            n_cnt  = r_cnt + 1'b1;
            if (i_cls.col < r_lc) n_lc = i_cls.col;
            if (i_cls.col > r_mc) n_mc = i_cls.col;
            if (i_cls.row < r_lr) n_lr = i_cls.row;
            if (i_cls.row > r_mr) n_mr = i_cls.row;
        end
        found = n_cnt > i_cfg.area_floor;
        tc = {r_remc[CntW-1:0], r_qc[SumW-1]};
        tr = {r_remr[CntW-1:0], r_qr[SumW-1]};
    end

    // Result word and its valid flag.
    always_comb begin
        n_ov  = r_ov && !i_ready;
        n_res = r_res;
        case (r_st)
            ST_RUN: begin
                if (take) begin
                    n_res           = '0;
                    n_res.is_target = i_cls.mark;
                    if (i_cls.last) begin
                        n_res.frame_done  = 1'b1;
                        n_res.found       = found;
                        n_res.box_left    = n_lc;
                        n_res.box_top     = n_lr;
                        n_res.box_right   = n_mc;
                        n_res.box_bottom  = n_mr;
                        n_res.pixel_count = n_cnt;
                        if (!found) n_ov = 1'b1;
                    end else begin
                        n_ov = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_res.center_col = r_qc[7:0];
                    n_res.center_row = r_qr[6:0];
                    n_ov = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_RUN;
            r_ov   <= 1'b0;
            r_csum <= '0;
            r_rsum <= '0;
            r_cnt  <= '0;
            r_lc   <= ColW'(Width);
            r_mc   <= '0;
            r_lr   <= RowW'(Height);
            r_mr   <= '0;
            r_step <= '0;
        end else begin
            r_ov <= n_ov;
            case (r_st)
                ST_RUN: begin
                    if (take) begin
                        if (i_cls.last) begin
                            r_csum <= '0;
                            r_rsum <= '0;
                            r_cnt  <= '0;
                            r_lc   <= ColW'(Width);
                            r_mc   <= '0;
                            r_lr   <= RowW'(Height);
                            r_mr   <= '0;
                            if (found) begin
                                r_qc   <= n_csum;
                                r_qr   <= n_rsum;
                                r_remc <= '0;
                                r_remr <= '0;
                                r_div  <= n_cnt;
                                r_step <= '0;
                                r_st   <= ST_DIV;
                            end
                        end else begin
                            r_csum <= n_csum;
                            r_rsum <= n_rsum;
                            r_cnt  <= n_cnt;
                            r_lc   <= n_lc;
                            r_mc   <= n_mc;
                            r_lr   <= n_lr;
                            r_mr   <= n_mr;
                        end
                    end
                end
                ST_DIV: begin
                    if (tc >= {1'b0, r_div}) begin
                        r_remc <= tc - {1'b0, r_div};
                        r_qc   <= {r_qc[SumW-2:0], 1'b1};
                    end else begin
                        r_remc <= tc;
                        r_qc   <= {r_qc[SumW-2:0], 1'b0};
                    end
                    if (tr >= {1'b0, r_div}) begin
                        r_remr <= tr - {1'b0, r_div};
                        r_qr   <= {r_qr[SumW-2:0], 1'b1};
                    end else begin
                        r_remr <= tr;
                        r_qr   <= {r_qr[SumW-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == CW'(SumW - 1)) r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) r_st <= ST_RUN;
                end
                default: r_st <= ST_RUN;
            endcase
        end
    end

    `HCB_ASSERT_IMP(a_idle_in_div, i_clk, i_rst_n, r_st != ST_RUN, !o_ready)
    `HCB_ASSERT_IMP(a_done_has_box, i_clk, i_rst_n,
        r_ov && r_res.frame_done && r_res.pixel_count == '0, r_res.box_left == ColW'(Width))
    `HCB_ASSERT_IMP(a_found_count, i_clk, i_rst_n,
        r_ov && r_res.found, r_res.pixel_count > i_cfg.area_floor)
endmodule
